// File: rtl/tsom_pkg.sv
// shared types and constants for the timestamp ordered stream merge
// no dependencies
package tsom_pkg;

	localparam int QUEUE_W = 3;
	localparam int TIME_W = 63;
	localparam int PAY_W = 32;
	localparam int CFG_W = 4;
	localparam int MAX_PASSES = 8;
	localparam int EARLY_MIN_FILL = 2;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd2;

	typedef enum logic [1:0] {
		KIND_RELEASED = 2'd0,
		KIND_OUT_OF_ORDER = 2'd1,
		KIND_BEFORE_START = 2'd2,
		KIND_REFUSED = 2'd3
	} kind_t;

	typedef struct packed {
		logic [QUEUE_W-1:0] queue;
		logic [TIME_W-1:0] time_v;
		logic [PAY_W-1:0] payload;
		kind_t kind;
	} res_t;

endpackage

// File: rtl/tsom_in_if.sv
// input channel interface: valid/ready with queue, time and payload
// depends on tsom_pkg
interface tsom_in_if;
	logic valid;
	logic ready;
	logic [tsom_pkg::QUEUE_W-1:0] in_queue;
	logic [tsom_pkg::TIME_W-1:0] in_time;
	logic [tsom_pkg::PAY_W-1:0] in_payload;

	modport source (output valid, in_queue, in_time, in_payload, input ready);
	modport sink (input valid, in_queue, in_time, in_payload, output ready);
endinterface

// File: rtl/tsom_out_if.sv
// result channel interface: valid/ready with queue, time, payload, kind, last
// depends on tsom_pkg
interface tsom_out_if;
	logic valid;
	logic ready;
	logic [tsom_pkg::QUEUE_W-1:0] out_queue;
	logic [tsom_pkg::TIME_W-1:0] out_time;
	logic [tsom_pkg::PAY_W-1:0] out_payload;
	logic [1:0] out_kind;
	logic out_last;

	modport source (output valid, out_queue, out_time, out_payload, out_kind, out_last,
		input ready);
	modport sink (input valid, out_queue, out_time, out_payload, out_kind, out_last,
		output ready);
endinterface

// File: rtl/tsom_store.sv
// fifo storage for all queues: one write port, one registered read port
// depends on tsom_pkg
module tsom_store #(
	parameter int AW = 11,
	parameter int PW = 32
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [tsom_pkg::TIME_W-1:0] wtime,
	input  logic [PW-1:0] wpay,
	input  logic [AW-1:0] raddr,
	output logic [tsom_pkg::TIME_W-1:0] rtime,
	output logic [PW-1:0] rpay
);
	localparam int DEPTH = 1 << AW;

	logic [tsom_pkg::TIME_W-1:0] time_mem [DEPTH];
	logic [PW-1:0] pay_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			time_mem[waddr] <= wtime;
			pay_mem[waddr] <= wpay;
		end
		rtime <= time_mem[raddr];
		rpay <= pay_mem[raddr];
	end
endmodule

// File: rtl/timestamp_ordered_stream_merge.sv
// top level: sequencer, queue pointers and result staging of the merge
// depends on tsom_pkg, tsom_in_if, tsom_out_if, tsom_store
//
// usage
//   in_item carries (in_queue, in_time, in_payload); a transfer pushes the item
//   into the fifo of its queue, or refuses it (kind 3) when the queue index is
//   not active or that fifo is full. after a push up to min(active, 8) merge
//   passes run, each giving at most one result on out_item; out_last marks the
//   final result of an input. a step can also give no result at all.
//   cfg_we/cfg_wdata write queues_in_use; write it only while idle.
//   ready is high only in idle. a pass reads the queue heads one at a time
//   through the single read port of the storage and one shared comparator.
//   a step runs from the transfer to the next ready; a receiver stall
//   makes it longer.
//   results are staged one behind, so each leaves once the next is known.
//   a stalled receiver stalls the sequencer; nothing is lost.
//   reset clears pointers, fill counts, start and release times; the
//   storage itself is not cleared and needs no clearing pass.
module timestamp_ordered_stream_merge #(
	parameter int NUM_QUEUES = 8,
	parameter int FIFO_DEPTH = 256,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [tsom_pkg::CFG_W-1:0] cfg_wdata,
	tsom_in_if.sink in_item,
	tsom_out_if.source out_item
);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FW = $clog2(FIFO_DEPTH + 1);
	localparam int PW = (PAYLOAD_BITS < tsom_pkg::PAY_W) ? PAYLOAD_BITS : tsom_pkg::PAY_W;
	localparam int AW = QW + PTW;
	localparam int CW = tsom_pkg::CFG_W;
	localparam int TW = tsom_pkg::TIME_W;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_DROP_OOO, S_DECIDE, S_NEXT_CMP,
		S_PASS_END, S_EMIT, S_FIN
	} state_t;

	function automatic logic [PTW-1:0] adv(input logic [PTW-1:0] p);
		if (32'(p) >= FIFO_DEPTH - 1) begin
			return '0;
		end
		return p + PTW'(1);
	endfunction

	state_t state_q, nxt_q;
	logic [CW-1:0] cfg_q;
	logic [PTW-1:0] head_q [NUM_QUEUES];
	logic [PTW-1:0] tail_q [NUM_QUEUES];
	logic [FW-1:0] fill_q [NUM_QUEUES];
	logic [TW-1:0] last_rel_q, start_q, best_t_q, max_t_q;
	logic [PW-1:0] best_p_q;
	logic known_q, bv_q;
	logic [QW-1:0] sq_q, bq_q;
	logic [CW-1:0] pass_q;
	tsom_pkg::res_t res_q, hold_q, out_q;
	logic hold_v_q, out_v_q, out_last_q;

	logic [CW-1:0] act, passes;
	logic [QW-1:0] qx, sel_idx;
	logic [PTW-1:0] sel_head, sel_tail;
	logic [FW-1:0] sel_fill;
	logic in_acc, refuse, out_free, out_load, last_scan, take;
	logic mem_we;
	logic [AW-1:0] waddr, raddr;
	logic [TW-1:0] rd_t, nb_t, st;
	logic [PW-1:0] rd_p, nb_p;
	logic [QW-1:0] nb_q;

	always_comb begin
		if (cfg_q == '0) begin
			act = CW'(1);
		end else if (32'(cfg_q) > NUM_QUEUES) begin
			act = CW'(NUM_QUEUES);
		end else begin
			act = cfg_q;
		end
		passes = (32'(act) > tsom_pkg::MAX_PASSES) ? CW'(tsom_pkg::MAX_PASSES) : act;
	end

	assign qx = QW'(in_item.in_queue);

	always_comb begin
		case (state_q)
			S_IDLE: sel_idx = qx;
			S_SCAN_RD, S_SCAN_CMP: sel_idx = sq_q;
			default: sel_idx = bq_q;
		endcase
	end

	assign sel_head = head_q[sel_idx];
	assign sel_tail = tail_q[sel_idx];
	assign sel_fill = fill_q[sel_idx];

	assign in_item.ready = (state_q == S_IDLE);
	assign in_acc = in_item.valid && in_item.ready;
	assign refuse = (CW'(in_item.in_queue) >= act) || (32'(sel_fill) >= FIFO_DEPTH);
	assign mem_we = in_acc && !refuse;
	assign waddr = {qx, sel_tail};
	assign raddr = (state_q == S_SCAN_RD) ? {sq_q, sel_head} : {bq_q, adv(sel_head)};
	assign out_free = !out_v_q || out_item.ready;
	assign out_load = ((state_q == S_EMIT) || (state_q == S_FIN)) && hold_v_q && out_free;

	assign take = !bv_q || (rd_t < best_t_q);
	assign nb_t = take ? rd_t : best_t_q;
	assign nb_p = take ? rd_p : best_p_q;
	assign nb_q = take ? sq_q : bq_q;
	assign last_scan = (CW'(sq_q) == act - CW'(1));
	assign st = known_q ? start_q : max_t_q;

	tsom_store #(.AW(AW), .PW(PW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wtime (in_item.in_time),
		.wpay  (in_item.in_payload[PW-1:0]),
		.raddr (raddr),
		.rtime (rd_t),
		.rpay  (rd_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nxt_q <= S_IDLE;
			cfg_q <= tsom_pkg::CFG_RESET;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			last_rel_q <= '0;
			start_q <= '0;
			known_q <= 1'b0;
			bv_q <= 1'b0;
			sq_q <= '0;
			bq_q <= '0;
			pass_q <= '0;
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_item.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (refuse) begin
							res_q <= '{queue: in_item.in_queue, time_v: in_item.in_time,
								payload: tsom_pkg::PAY_W'(in_item.in_payload[PW-1:0]),
								kind: tsom_pkg::KIND_REFUSED};
							nxt_q <= S_FIN;
							state_q <= S_EMIT;
						end else begin
							tail_q[qx] <= adv(sel_tail);
							fill_q[qx] <= sel_fill + FW'(1);
							sq_q <= '0;
							bv_q <= 1'b0;
							max_t_q <= '0;
							pass_q <= '0;
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= (sel_fill == '0) ? S_FIN : S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					best_t_q <= nb_t;
					best_p_q <= nb_p;
					bq_q <= nb_q;
					bv_q <= 1'b1;
					if (rd_t > max_t_q) begin
						max_t_q <= rd_t;
					end
					if (last_rel_q > nb_t) begin
						state_q <= S_DROP_OOO;
					end else if (last_scan) begin
						state_q <= S_DECIDE;
					end else begin
						sq_q <= sq_q + QW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_DROP_OOO: begin
					head_q[bq_q] <= adv(sel_head);
					fill_q[bq_q] <= sel_fill - FW'(1);
					res_q <= '{queue: tsom_pkg::QUEUE_W'(bq_q), time_v: best_t_q,
						payload: tsom_pkg::PAY_W'(best_p_q),
						kind: tsom_pkg::KIND_OUT_OF_ORDER};
					nxt_q <= S_FIN;
					state_q <= S_EMIT;
				end
				S_DECIDE: begin
					start_q <= st;
					known_q <= 1'b1;
					head_q[bq_q] <= adv(sel_head);
					fill_q[bq_q] <= sel_fill - FW'(1);
					res_q <= '{queue: tsom_pkg::QUEUE_W'(bq_q), time_v: best_t_q,
						payload: tsom_pkg::PAY_W'(best_p_q),
						kind: ((best_t_q >= st)
							|| (32'(sel_fill) >= tsom_pkg::EARLY_MIN_FILL))
							? tsom_pkg::KIND_RELEASED : tsom_pkg::KIND_BEFORE_START};
					nxt_q <= S_PASS_END;
					if (best_t_q >= st) begin
						last_rel_q <= best_t_q;
						state_q <= S_EMIT;
					end else if (32'(sel_fill) < tsom_pkg::EARLY_MIN_FILL) begin
						last_rel_q <= best_t_q;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_NEXT_CMP;
					end
				end
				S_NEXT_CMP: begin
					if (rd_t > start_q) begin
						last_rel_q <= best_t_q;
					end else begin
						res_q.kind <= tsom_pkg::KIND_BEFORE_START;
					end
					state_q <= S_EMIT;
				end
				S_PASS_END: begin
					if (pass_q + CW'(1) < passes) begin
						pass_q <= pass_q + CW'(1);
						sq_q <= '0;
						bv_q <= 1'b0;
						max_t_q <= '0;
						state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_EMIT: begin
					if (!hold_v_q) begin
						hold_q <= res_q;
						hold_v_q <= 1'b1;
						state_q <= nxt_q;
					end else if (out_free) begin
						out_q <= hold_q;
						out_last_q <= 1'b0;
						hold_q <= res_q;
						state_q <= nxt_q;
					end
				end
				S_FIN: begin
					if (!hold_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q <= hold_q;
						out_last_q <= 1'b1;
						hold_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_item.valid = out_v_q;
	assign out_item.out_queue = out_q.queue;
	assign out_item.out_time = out_q.time_v;
	assign out_item.out_payload = out_q.payload;
	assign out_item.out_kind = out_q.kind;
	assign out_item.out_last = out_last_q;
endmodule

// File: rtl/tsom_checker.sv
// port level checks of the merge block, attached by bind
// depends on tsom_pkg
module tsom_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] out_kind,
	input logic out_last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_refuse_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == tsom_pkg::KIND_REFUSED) |-> out_last)
		else $error("refused item not last of its step");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an input transfer");
endmodule

bind timestamp_ordered_stream_merge tsom_checker u_tsom_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_item.valid),
	.in_ready  (in_item.ready),
	.out_valid (out_item.valid),
	.out_ready (out_item.ready),
	.out_kind  (out_item.out_kind),
	.out_last  (out_item.out_last)
);

// File: verif/timestamp_ordered_stream_merge_tb.sv
// testbench for timestamp_ordered_stream_merge: random and directed items, scoreboard check
// depends on tsom_pkg, tsom_in_if, tsom_out_if and the rtl top level
`timescale 1ns / 100ps

module timestamp_ordered_stream_merge_tb;

	localparam int NQ = 8;
	localparam int DEPTH = 256;
	localparam int STALL_LIMIT = 6000;
	localparam int QW = tsom_pkg::QUEUE_W;
	localparam int TW = tsom_pkg::TIME_W;
	localparam int PYW = tsom_pkg::PAY_W;
	localparam int CW = tsom_pkg::CFG_W;

	typedef struct {
		logic [QW-1:0] queue;
		logic [TW-1:0] time_v;
		logic [PYW-1:0] payload;
	} sample_t;

	typedef struct {
		logic [QW-1:0] queue;
		logic [TW-1:0] time_v;
		logic [PYW-1:0] payload;
		tsom_pkg::kind_t kind;
		logic last;
	} merged_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CW-1:0] cfg_wdata;

	tsom_in_if in_ch();
	tsom_out_if out_ch();

	timestamp_ordered_stream_merge DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_item(in_ch),
		.out_item(out_ch)
	);

	always #5 clk = ~clk;

	// merge state mirror
	logic [TW-1:0] q_time [NQ][DEPTH];
	logic [PYW-1:0] q_pay [NQ][DEPTH];
	int unsigned q_head [NQ];
	int unsigned q_tail [NQ];
	int unsigned q_fill [NQ];
	logic [TW-1:0] last_out_time;
	logic [TW-1:0] start_ts;
	bit start_known;
	logic [CW-1:0] active_cfg;

	sample_t pending_samples[$];
	merged_t merged_expected[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	int send_gap = 0;
	int take_gap = 0;
	logic [TW-1:0] time_base = 63'd1000;
	bit wide_times = 1'b0;

	function automatic int unsigned active_queues();
		if (active_cfg < 1) return 1;
		if (active_cfg > NQ) return NQ;
		return active_cfg;
	endfunction

	function automatic void expect_one(int unsigned q, logic [TW-1:0] t,
		logic [PYW-1:0] p, tsom_pkg::kind_t k);
		merged_t m;
		m.queue = QW'(q);
		m.time_v = t;
		m.payload = p;
		m.kind = k;
		m.last = 1'b0;
		merged_expected.push_back(m);
	endfunction

	function automatic void pop_head(int unsigned q, output logic [TW-1:0] t,
		output logic [PYW-1:0] p);
		t = q_time[q][q_head[q]];
		p = q_pay[q][q_head[q]];
		q_head[q] = (q_head[q] + 1) % DEPTH;
		if (q_fill[q] > 0) q_fill[q]--;
	endfunction

	function automatic int merge_passes();
		int unsigned act;
		int n;
		int best;
		int unsigned sz;
		logic [TW-1:0] best_t, t, mx;
		logic [PYW-1:0] p;
		act = active_queues();
		n = 0;
		for (int pass = 0; pass < act && pass < tsom_pkg::MAX_PASSES; pass++) begin
			best = -1;
			best_t = '0;
			for (int q = 0; q < act; q++) begin
				if (q_fill[q] == 0) return n;
				t = q_time[q][q_head[q]];
				if (best < 0 || t < best_t) begin
					best = q;
					best_t = t;
				end
				if (last_out_time > best_t) begin
					pop_head(best, t, p);
					expect_one(best, t, p, tsom_pkg::KIND_OUT_OF_ORDER);
					return n + 1;
				end
			end
			if (!start_known) begin
				mx = '0;
				for (int q = 0; q < act; q++)
					if (q_time[q][q_head[q]] > mx) mx = q_time[q][q_head[q]];
				start_ts = mx;
				start_known = 1'b1;
			end
			sz = q_fill[best];
			pop_head(best, t, p);
			if (t >= start_ts) begin
				last_out_time = t;
				expect_one(best, t, p, tsom_pkg::KIND_RELEASED);
			end else if (sz < tsom_pkg::EARLY_MIN_FILL) begin
				last_out_time = t;
				expect_one(best, t, p, tsom_pkg::KIND_BEFORE_START);
			end else if (q_time[best][q_head[best]] > start_ts) begin
				last_out_time = t;
				expect_one(best, t, p, tsom_pkg::KIND_RELEASED);
			end else begin
				expect_one(best, t, p, tsom_pkg::KIND_BEFORE_START);
			end
			n++;
		end
		return n;
	endfunction

	function automatic void predict_merge(sample_t s);
		int n;
		if (s.queue >= active_queues() || q_fill[s.queue] >= DEPTH) begin
			expect_one(s.queue, s.time_v, s.payload, tsom_pkg::KIND_REFUSED);
			merged_expected[$].last = 1'b1;
			return;
		end
		q_time[s.queue][q_tail[s.queue]] = s.time_v;
		q_pay[s.queue][q_tail[s.queue]] = s.payload;
		q_tail[s.queue] = (q_tail[s.queue] + 1) % DEPTH;
		q_fill[s.queue]++;
		n = merge_passes();
		if (n > 0) merged_expected[$].last = 1'b1;
	endfunction

	// input driver
	always @(posedge clk) begin
		sample_t s;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.in_queue <= '0;
			in_ch.in_time <= '0;
			in_ch.in_payload <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				s.queue = in_ch.in_queue;
				s.time_v = in_ch.in_time;
				s.payload = in_ch.in_payload;
				predict_merge(s);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					s = pending_samples.pop_front();
					in_ch.in_queue <= s.queue;
					in_ch.in_time <= s.time_v;
					in_ch.in_payload <= s.payload;
					in_ch.valid <= 1'b1;
					if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 11);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk) begin
		merged_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (merged_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result q=%0d t=%0h p=%0h kind=%0d last=%0b",
							out_ch.out_queue, out_ch.out_time, out_ch.out_payload,
							out_ch.out_kind, out_ch.out_last);
				end else begin
					e = merged_expected.pop_front();
					if (out_ch.out_queue !== e.queue || out_ch.out_time !== e.time_v ||
						out_ch.out_payload !== e.payload || out_ch.out_kind !== e.kind ||
						out_ch.out_last !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch exp q=%0d t=%0h p=%0h kind=%0d last=%0b,",
								" got q=%0d t=%0h p=%0h kind=%0d last=%0b"},
								e.queue, e.time_v, e.payload, e.kind, e.last,
								out_ch.out_queue, out_ch.out_time, out_ch.out_payload,
								out_ch.out_kind, out_ch.out_last);
					end
				end
			end
			if (take_gap > 0) begin
				take_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 4) == 0) take_gap = $urandom_range(1, 11);
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic void add_sample(int unsigned q, logic [TW-1:0] t,
		logic [PYW-1:0] p);
		sample_t s;
		s.queue = QW'(q);
		s.time_v = t;
		s.payload = p;
		pending_samples.push_back(s);
	endfunction

	function automatic void add_random(int count, int unsigned act);
		int unsigned q;
		logic [TW-1:0] t;
		for (int i = 0; i < count; i++) begin
			q = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, act - 1);
			time_base = time_base + TW'($urandom_range(0, 40));
			if (wide_times)
				t = TW'({$urandom(), $urandom()});
			else if ($urandom_range(0, 7) == 0)
				t = time_base - TW'($urandom_range(0, 200));
			else
				t = time_base + TW'($urandom_range(0, 60));
			add_sample(q, t, $urandom());
		end
	endfunction

	task automatic drain_and_write(logic [CW-1:0] value);
		while (pending_samples.size() > 0 || in_ch.valid || merged_expected.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		active_cfg = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		for (int q = 0; q < NQ; q++) begin
			q_head[q] = 0;
			q_tail[q] = 0;
			q_fill[q] = 0;
		end
		last_out_time = '0;
		start_ts = '0;
		start_known = 1'b0;
		active_cfg = tsom_pkg::CFG_RESET;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: start latch, early drop, release, out of order, inactive queues
		add_sample(0, 63'd100, 32'h0000_0001);
		add_sample(1, 63'd50, 32'hFFFF_FFFF);
		add_sample(1, 63'd150, 32'h0000_0000);
		add_sample(0, 63'd0, 32'hA5A5_5A5A);
		add_sample(0, 63'd120, 32'h1234_5678);
		add_sample(0, 63'd130, 32'h8765_4321);
		add_sample(1, 63'd110, 32'h0F0F_F0F0);
		add_sample(1, 63'd200, 32'hDEAD_BEEF);
		add_sample(2, 63'd302, $urandom());
		add_sample(7, 63'd307, $urandom());
		add_sample(0, 63'd210, 32'h5555_AAAA);
		add_sample(1, 63'd220, 32'hAAAA_5555);
		add_random(6, 2);

		// full fifo: queue 0 alone never merges with eight queues active
		drain_and_write(4'd8);
		for (int i = 0; i < DEPTH + 1; i++)
			add_sample(0, time_base + 63'd5000 + TW'(i), $urandom());
		for (int q = 1; q < NQ; q++) add_sample(q, time_base + 63'd4000 + TW'(q), $urandom());
		time_base = time_base + 63'd6000;

		drain_and_write(4'd0);
		add_random(4, 1);

		drain_and_write(4'd15);
		add_random(5, 8);

		drain_and_write(4'd3);
		add_random(5, 3);

		drain_and_write(4'd5);
		add_random(5, 5);

		drain_and_write(4'd8);
		calm = 1'b1;
		add_random(5, 8);
		wide_times = 1'b1;
		add_random(3, 8);

		while (pending_samples.size() > 0 || in_ch.valid || merged_expected.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && merged_expected.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
